### rtl/bcoo_pkg.sv
`default_nettype none

package bcoo_pkg;

  // Action codes carried by an input transaction.
  typedef enum logic [2:0] {
    ACT_CLEAR       = 3'd0,
    ACT_LOAD_X      = 3'd1,
    ACT_BLOCK_VALUE = 3'd2,
    ACT_FINISH      = 3'd3,
    ACT_READ_Y      = 3'd4
  } action_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_VAL_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_BLOCK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_PER_BLOCK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLOCK_ROW = 2'd2;

  // Register reset values.
  localparam logic [3:0]  ROWS_PER_BLOCK_RST  = 4'd4;
  localparam logic [3:0]  COLS_PER_BLOCK_RST  = 4'd4;
  localparam logic [15:0] FIRST_BLOCK_ROW_RST = 16'd0;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_XIDX,
    S_XWAIT,
    S_XMUL,
    S_XACC,
    S_FBASE,
    S_FBWAIT,
    S_FRD,
    S_FADD,
    S_FWR,
    S_YOUT
  } state_e;

  // One input item.
  typedef struct packed {
    logic [2:0]         action;
    logic [15:0]        block_row;
    logic [11:0]        block_col;
    logic [2:0]         row_in_block;
    logic [2:0]         col_in_block;
    logic [11:0]        vector_index;
    logic signed [31:0] data_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [11:0]        y_index;
    logic signed [31:0] y_value;
  } out_item_t;

  // One configuration write.
  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_wr_t;

endpackage

`default_nettype wire

### rtl/bcoo_stream_if.sv
`default_nettype none

// Valid/ready channel carrying one payload per transaction.
interface bcoo_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/block_coo_spmv_engine_top.sv
`default_nettype none

// Block-COO sparse matrix-vector engine. One item is accepted at a time and in_i.ready
// is low while it is worked on; all products, index computations and output updates go
// through one two-stage multiply-add unit. A load_x is written in its accepting cycle;
// a read_y reads the output memory, then waits for the result register to drain. For a
// block_value the x index and, after the x memory read, the multiply-add pass through
// the shared unit in turn; it ends early when its position lies outside the block or
// its x index lies past the x store. When a block row is pending and the value's block
// row differs from it, a flush runs first: the base position is formed in the shared
// unit (the flush ends there when the block row lies below the first block row), then
// rows_per_block rows each do a read, add and write of the output memory; a row that
// falls outside the output memory is skipped. A finish runs the same flush. After reset,
// and on every clear, a clearing pass writes zero to each of the Y_DEPTH output entries,
// one a cycle, while no item is accepted; configuration writes are always taken.
module block_coo_spmv_engine_top import bcoo_pkg::*; #(
  parameter int unsigned MAX_BLOCK_DIM = 8,
  parameter int unsigned X_DEPTH       = 4096,
  parameter int unsigned Y_DEPTH       = 4096,
  parameter int unsigned VALUE_WIDTH   = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  bcoo_stream_if.sink   cfg_i,
  bcoo_stream_if.sink   in_i,
  bcoo_stream_if.source out_o
);

  localparam int unsigned DIM_W  = $clog2(MAX_BLOCK_DIM + 1);
  localparam int unsigned AIDX_W = (MAX_BLOCK_DIM > 1) ? $clog2(MAX_BLOCK_DIM) : 1;
  localparam int unsigned XA_W   = $clog2(X_DEPTH);
  localparam int unsigned YA_W   = $clog2(Y_DEPTH);
  localparam int unsigned MW     = (VALUE_WIDTH > 24) ? VALUE_WIDTH : 24;

  // Block size saturated to the supported range.
  function automatic logic [DIM_W-1:0] dim_sat(input logic [3:0] v);
    if (v == 4'd0) begin
      return DIM_W'(1);
    end else if (32'(v) > MAX_BLOCK_DIM) begin
      return DIM_W'(MAX_BLOCK_DIM);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  // Configuration registers.
  logic [3:0]  rows_q;
  logic [3:0]  cols_q;
  logic [15:0] first_q;

  // Sequencer and block state.
  state_e                 state_q, state_d;
  in_item_t               item_q;
  logic [15:0]            cur_q;
  logic                   seen_q;
  logic [DIM_W-1:0]       r_q;
  logic [MW-1:0]          base_q;
  logic [YA_W-1:0]        clr_cnt_q;
  logic                   yzero_q;
  logic [VALUE_WIDTH-1:0] acc_q [MAX_BLOCK_DIM];

  // Output register.
  logic      out_valid_q;
  out_item_t out_data_q;

  // Memories.
  logic [VALUE_WIDTH-1:0] x_mem [X_DEPTH];
  logic [VALUE_WIDTH-1:0] y_mem [Y_DEPTH];
  logic [VALUE_WIDTH-1:0] x_rdata_q;
  logic [VALUE_WIDTH-1:0] y_rdata_q;

  // Derived values.
  logic                   in_acc;
  logic [DIM_W-1:0]       rows_eff;
  logic [DIM_W-1:0]       cols_eff;
  logic                   pos_in_block;
  logic [MW-1:0]          pos;
  logic                   pos_ok;
  logic                   last_row;
  logic                   cur_ge;
  logic [15:0]            diff;
  logic                   flushing;
  logic [AIDX_W-1:0]      acc_sel;
  logic [VALUE_WIDTH-1:0] acc_rd;
  logic [VALUE_WIDTH-1:0] val_ext;
  logic                   xi_ok;
  logic                   in_x_ok;
  logic                   in_y_ok;
  logic                   flush_end;
  logic                   row_step;
  logic                   out_load;
  state_e                 cont_state;

  // Shared unit controls and memory port controls.
  logic                   mac_start;
  logic [MW-1:0]          mac_a;
  logic [MW-1:0]          mac_b;
  logic [MW-1:0]          mac_c;
  logic                   mac_done;
  logic [MW-1:0]          mac_p;
  logic                   x_we;
  logic [XA_W-1:0]        x_waddr;
  logic [VALUE_WIDTH-1:0] x_wdata;
  logic                   x_re;
  logic [XA_W-1:0]        x_raddr;
  logic                   y_we;
  logic [YA_W-1:0]        y_waddr;
  logic [VALUE_WIDTH-1:0] y_wdata;
  logic                   y_re;
  logic [YA_W-1:0]        y_raddr;

  bcoo_mac #(
    .W (MW)
  ) u_bcoo_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .a_i     (mac_a),
    .b_i     (mac_b),
    .c_i     (mac_c),
    .done_o  (mac_done),
    .p_o     (mac_p)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;

  assign rows_eff     = dim_sat(rows_q);
  assign cols_eff     = dim_sat(cols_q);
  assign pos_in_block = (item_q.row_in_block < rows_eff) && (item_q.col_in_block < cols_eff);
  assign pos          = base_q + MW'(r_q);
  assign pos_ok       = pos < MW'(Y_DEPTH);
  assign last_row     = (r_q == (rows_eff - DIM_W'(1)));
  assign cur_ge       = (cur_q >= first_q);
  assign diff         = cur_q - first_q;
  assign val_ext      = VALUE_WIDTH'($signed(item_q.data_value));
  assign xi_ok        = mac_p < MW'(X_DEPTH);
  assign in_x_ok      = 32'(in_i.data.vector_index) < X_DEPTH;
  assign in_y_ok      = 32'(in_i.data.vector_index) < Y_DEPTH;

  // The accumulators have one read point: the flush row or the value's row.
  assign flushing = (state_q == S_FBASE) || (state_q == S_FBWAIT) || (state_q == S_FRD) ||
                    (state_q == S_FADD) || (state_q == S_FWR);
  assign acc_sel  = flushing ? AIDX_W'(r_q) : AIDX_W'(item_q.row_in_block);
  assign acc_rd   = acc_q[acc_sel];

  // A flush ends when the base is negative or after its last row.
  assign flush_end = ((state_q == S_FBASE) && !cur_ge) ||
                     ((state_q == S_FRD) && !pos_ok && last_row) ||
                     ((state_q == S_FWR) && mac_done && last_row);
  assign row_step  = ((state_q == S_FRD) && !pos_ok && !last_row) ||
                     ((state_q == S_FWR) && mac_done && !last_row);
  assign out_load  = (state_q == S_YOUT) && (!out_valid_q || out_o.ready);

  // After a flush, a block value goes on to its own product.
  assign cont_state = (item_q.action == ACT_BLOCK_VALUE) ? S_XIDX : S_IDLE;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.data.action)
            ACT_CLEAR:       state_d = S_CLEAR;
            ACT_BLOCK_VALUE: begin
              state_d = (seen_q && (in_i.data.block_row != cur_q)) ? S_FBASE : S_XIDX;
            end
            ACT_FINISH:      state_d = seen_q ? S_FBASE : S_IDLE;
            ACT_READ_Y:      state_d = S_YOUT;
            default:         state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_cnt_q == YA_W'(Y_DEPTH - 1)) state_d = S_IDLE;
      end
      S_XIDX: begin
        state_d = pos_in_block ? S_XWAIT : S_IDLE;
      end
      S_XWAIT: begin
        if (mac_done) state_d = xi_ok ? S_XMUL : S_IDLE;
      end
      S_XMUL: begin
        state_d = S_XACC;
      end
      S_XACC: begin
        if (mac_done) state_d = S_IDLE;
      end
      S_FBASE: begin
        state_d = cur_ge ? S_FBWAIT : cont_state;
      end
      S_FBWAIT: begin
        if (mac_done) state_d = S_FRD;
      end
      S_FRD: begin
        if (pos_ok) begin
          state_d = S_FADD;
        end else if (last_row) begin
          state_d = cont_state;
        end
      end
      S_FADD: begin
        state_d = S_FWR;
      end
      S_FWR: begin
        if (mac_done) state_d = last_row ? cont_state : S_FRD;
      end
      S_YOUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: shared unit operands and memory ports.
  always_comb begin
    mac_start = 1'b0;
    mac_a     = '0;
    mac_b     = '0;
    mac_c     = '0;
    x_we      = 1'b0;
    x_waddr   = XA_W'(in_i.data.vector_index);
    x_wdata   = VALUE_WIDTH'($signed(in_i.data.data_value));
    x_re      = 1'b0;
    x_raddr   = XA_W'(mac_p);
    y_we      = 1'b0;
    y_waddr   = clr_cnt_q;
    y_wdata   = '0;
    y_re      = 1'b0;
    y_raddr   = YA_W'(pos);
    case (state_q)
      S_IDLE: begin
        x_we    = in_acc && (in_i.data.action == ACT_LOAD_X) && in_x_ok;
        y_re    = in_acc && (in_i.data.action == ACT_READ_Y) && in_y_ok;
        y_raddr = YA_W'(in_i.data.vector_index);
      end
      S_CLEAR: begin
        y_we = 1'b1;
      end
      S_XIDX: begin
        // x index = block_col * cols + col_in_block
        mac_start = pos_in_block;
        mac_a     = MW'(item_q.block_col);
        mac_b     = MW'(cols_eff);
        mac_c     = MW'(item_q.col_in_block);
      end
      S_XWAIT: begin
        x_re = mac_done && xi_ok;
      end
      S_XMUL: begin
        mac_start = 1'b1;
        mac_a     = MW'(val_ext);
        mac_b     = MW'(x_rdata_q);
        mac_c     = MW'(acc_rd);
      end
      S_FBASE: begin
        // base position = (current block row - first block row) * rows
        mac_start = cur_ge;
        mac_a     = MW'(diff);
        mac_b     = MW'(rows_eff);
      end
      S_FRD: begin
        y_re = pos_ok;
      end
      S_FADD: begin
        mac_start = 1'b1;
        mac_a     = MW'(acc_rd);
        mac_b     = MW'(1);
        mac_c     = MW'(y_rdata_q);
      end
      S_FWR: begin
        y_we    = mac_done;
        y_waddr = YA_W'(pos);
        y_wdata = mac_p[VALUE_WIDTH-1:0];
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ROWS_PER_BLOCK_RST;
      cols_q  <= COLS_PER_BLOCK_RST;
      first_q <= FIRST_BLOCK_ROW_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        CFG_ROWS_PER_BLOCK:  rows_q  <= cfg_i.data.value[3:0];
        CFG_COLS_PER_BLOCK:  cols_q  <= cfg_i.data.value[3:0];
        CFG_FIRST_BLOCK_ROW: first_q <= cfg_i.data.value[15:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state, row tracking and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      cur_q     <= '0;
      seen_q    <= 1'b0;
      r_q       <= '0;
      for (int i = 0; i < MAX_BLOCK_DIM; i++) acc_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + YA_W'(1);
      if (in_acc && (in_i.data.action == ACT_CLEAR)) begin
        clr_cnt_q <= '0;
        cur_q     <= '0;
        seen_q    <= 1'b0;
        for (int i = 0; i < MAX_BLOCK_DIM; i++) acc_q[i] <= '0;
      end
      if (in_acc && (in_i.data.action == ACT_FINISH)) seen_q <= 1'b0;
      if (state_q == S_XIDX) begin
        cur_q  <= item_q.block_row;
        seen_q <= 1'b1;
      end
      if ((state_q == S_XACC) && mac_done) begin
        acc_q[acc_sel] <= mac_p[VALUE_WIDTH-1:0];
      end
      if ((state_q == S_FBWAIT) && mac_done) r_q <= '0;
      if (row_step) r_q <= r_q + DIM_W'(1);
      if (flush_end) begin
        for (int i = 0; i < MAX_BLOCK_DIM; i++) acc_q[i] <= '0;
      end
    end
  end

  // Item and flush base payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q  <= in_i.data;
      yzero_q <= !in_y_ok;
    end
    if ((state_q == S_FBWAIT) && mac_done) base_q <= mac_p;
  end

  // Memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[x_waddr] <= x_wdata;
    if (x_re) x_rdata_q <= x_mem[x_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (y_we) y_mem[y_waddr] <= y_wdata;
    if (y_re) y_rdata_q <= y_mem[y_raddr];
  end

  // Output register: holds a result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.y_index <= item_q.vector_index;
      out_data_q.y_value <= yzero_q ? 32'sd0 : 32'(y_rdata_q);
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

`default_nettype wire

### rtl/bcoo_mac.sv
`default_nettype none

// Two-stage multiply-add unit: p = a * b + c, modulo 2**W.
// The result is valid while done_o is high; start_i reaches done_o through stage1_q and stage2_q.
module bcoo_mac #(
  parameter int unsigned W = 24
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] c_i,
  output logic              done_o,
  output logic [W-1:0]      p_o
);

  logic         stage1_q;
  logic         stage2_q;
  logic [W-1:0] prod_q;
  logic [W-1:0] addend_q;
  logic [W-1:0] sum_q;

  // Control pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      stage2_q <= 1'b0;
    end else begin
      stage1_q <= start_i;
      stage2_q <= stage1_q;
    end
  end

  // Multiply in the first stage, add in the second.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q   <= W'(a_i * b_i);
      addend_q <= c_i;
    end
    if (stage1_q) begin
      sum_q <= prod_q + addend_q;
    end
  end

  assign done_o = stage2_q;
  assign p_o    = sum_q;

endmodule

`default_nettype wire

### rtl/bcoo_checker.sv
`default_nettype none

// Port-level checks of the engine's sequencing.
module bcoo_checker import bcoo_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic [2:0] in_action_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before its transaction completed");

  // A block value always occupies the engine past its accepting cycle.
  a_block_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_action_i == ACT_BLOCK_VALUE) |=> !in_ready_i)
    else $error("engine ready right after a block value");

  // A read occupies the engine until its result is registered.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_action_i == ACT_READ_Y) |=> !in_ready_i)
    else $error("engine ready right after a read");

  // A vector load completes in its accepting cycle.
  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_action_i == ACT_LOAD_X) |=> in_ready_i)
    else $error("engine busy after a vector load");

  // A new result appears only while the engine is busy with a read.
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while the engine was idle");

endmodule

bind block_coo_spmv_engine_top bcoo_checker u_bcoo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.data.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

`default_nettype wire
